// File: src/maf_pkg.sv
`timescale 1ns / 1ps

package maf_pkg;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned DATA_W = 32;
  localparam int unsigned LEN_W  = 7;

  // Window length after reset.
  localparam logic [LEN_W-1:0] WINDOW_RESET = 7'd8;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_ADD,
    S_START,
    S_DIV,
    S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // take the input transfer and read the oldest sample
    logic sub;     // remove the oldest sample from the running sum
    logic add;     // add the new sample, store it and advance the ring
    logic start;   // start the divider on the updated sum
    logic load;    // load the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage

// File: src/maf_div.sv
`timescale 1ns / 1ps

module maf_div #(
  parameter int unsigned SUM_W = 38
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic signed [SUM_W-1:0]     dividend,
  input  logic [maf_pkg::LEN_W-1:0]   divisor,
  output logic                        busy,
  output logic [maf_pkg::DATA_W-1:0]  quotient
);
  import maf_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_W + 1);

  logic [SUM_W-1:0] mag;
  logic [LEN_W-1:0] rem;
  logic [LEN_W-1:0] dvs;
  logic             neg;
  logic [CNT_W-1:0] count;
  logic [LEN_W:0]   rem_sh;
  logic             ge;
  logic [LEN_W:0]   rem_diff;
  logic [SUM_W-1:0] q_signed;

  // One restoring step: shift in the next dividend bit and try the subtract.
  always_comb begin
    rem_sh   = {rem, mag[SUM_W-1]};
    ge       = rem_sh >= {1'b0, dvs};
    rem_diff = rem_sh - {1'b0, dvs};
  end

  // Control of the iteration count.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= CNT_W'(SUM_W);
    end else if (busy) begin
      count <= count - 1'b1;
      if (count == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // The magnitude register turns into the quotient bit by bit.
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      mag <= dividend[SUM_W-1] ? SUM_W'(-dividend) : SUM_W'(dividend);
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= ge ? rem_diff[LEN_W-1:0] : rem_sh[LEN_W-1:0];
      mag <= {mag[SUM_W-2:0], ge};
    end
  end

  // Restore the sign; C division truncates toward zero.
  assign q_signed = neg ? (~mag + 1'b1) : mag;
  assign quotient = q_signed[DATA_W-1:0];

endmodule

// File: src/maf_ctrl.sv
`timescale 1ns / 1ps

module maf_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output maf_pkg::cmd_t  cmd,
  input  maf_pkg::stat_t stat
);
  import maf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_SUB;
      S_SUB:   state_next = S_ADD;
      S_ADD:   state_next = S_START;
      S_START: state_next = S_DIV;
      S_DIV:   if (!stat.div_busy) state_next = S_OUT;
      S_OUT:   if (stat.out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
      end
      S_SUB:   cmd.sub   = 1'b1;
      S_ADD:   cmd.add   = 1'b1;
      S_START: cmd.start = 1'b1;
      S_DIV:   cmd       = '0;
      S_OUT:   cmd.load  = stat.out_free;
      default: cmd       = '0;
    endcase
  end

  // A load never happens without a finished division behind it.
  assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> $past(state == S_DIV || state == S_OUT))
    else $error("output load outside the result phase");

  // The controller issues at most one command per cycle.
  assert property (@(posedge clk) disable iff (rst) $onehot0(cmd))
    else $error("more than one command at once");

  // The divider reports busy right after it is started.
  assert property (@(posedge clk) disable iff (rst) cmd.start |=> stat.div_busy)
    else $error("divider not busy after start");

endmodule

// File: src/maf_datapath.sv
`timescale 1ns / 1ps

module maf_datapath #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [maf_pkg::LEN_W-1:0]   cfg_wdata,
  input  logic [maf_pkg::DATA_W-1:0]  sample,
  input  maf_pkg::cmd_t               cmd,
  output maf_pkg::stat_t              stat,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [maf_pkg::DATA_W-1:0]  out_mean,
  output logic [maf_pkg::LEN_W-1:0]   out_held
);
  import maf_pkg::*;

  // Longest window the 7-bit length register can ask for here.
  localparam int unsigned LEN_CAP = (WINDOW_MAX < 127) ? WINDOW_MAX : 127;
  localparam int unsigned SUM_W   = DATA_W + $clog2(LEN_CAP);
  localparam int unsigned IDX_W   = $clog2(WINDOW_MAX);
  localparam int unsigned CW      = (IDX_W > LEN_W) ? IDX_W : LEN_W;

  logic [LEN_W-1:0]        win_len;
  logic [LEN_W-1:0]        win_len_next;
  logic [IDX_W-1:0]        write_slot;
  logic [IDX_W-1:0]        cur_slot;
  logic [IDX_W-1:0]        slot_eff;
  logic [CW:0]             slot_inc;
  logic [LEN_W-1:0]        fill_count;
  logic signed [SUM_W-1:0] running_sum;
  logic [DATA_W-1:0]       new_sample;
  logic                    full;
  logic [DATA_W-1:0]       history [WINDOW_MAX];
  logic [DATA_W-1:0]       rd_data;
  logic                    div_busy;
  logic [DATA_W-1:0]       quotient;

  // Clamp a written length into 1..LEN_CAP.
  always_comb begin
    if (cfg_wdata == '0) begin
      win_len_next = LEN_W'(1);
    end else if (cfg_wdata > LEN_W'(LEN_CAP)) begin
      win_len_next = LEN_W'(LEN_CAP);
    end else begin
      win_len_next = cfg_wdata;
    end
  end

  // Slot of the oldest sample and the slot after the one being written.
  assign slot_eff = (CW'(write_slot) >= CW'(win_len)) ? '0 : write_slot;
  assign slot_inc = (CW + 1)'(cur_slot) + 1'b1;

  // Window length, ring position, fill count and running sum.
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len     <= WINDOW_RESET > LEN_W'(LEN_CAP) ? LEN_W'(LEN_CAP) : WINDOW_RESET;
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
    end else if (cfg_we) begin
      win_len     <= win_len_next;
      write_slot  <= '0;
      fill_count  <= '0;
      running_sum <= '0;
    end else begin
      if (cmd.sub && full) begin
        running_sum <= running_sum - {{(SUM_W-DATA_W){rd_data[DATA_W-1]}}, rd_data};
      end
      if (cmd.add) begin
        running_sum <= running_sum
                       + {{(SUM_W-DATA_W){new_sample[DATA_W-1]}}, new_sample};
        if (!full) begin
          fill_count <= fill_count + 1'b1;
        end
        write_slot <= (slot_inc >= (CW + 1)'(win_len)) ? '0 : cur_slot + 1'b1;
      end
    end
  end

  // Per-item registers taken at the input transfer.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      new_sample <= sample;
      cur_slot   <= slot_eff;
      full       <= fill_count >= win_len;
    end
  end

  // Sample ring: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (cmd.add) begin
      history[cur_slot] <= new_sample;
    end
    rd_data <= history[slot_eff];
  end

  maf_div #(
    .SUM_W (SUM_W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.start),
    .dividend (running_sum),
    .divisor  (fill_count),
    .busy     (div_busy),
    .quotient (quotient)
  );

  // Output register; it frees up in the cycle its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      out_mean <= quotient;
      out_held <= fill_count;
    end
  end

  assign stat.div_busy = div_busy;
  assign stat.out_free = !out_valid || out_ready;

  // The window never holds more samples than its length.
  assert property (@(posedge clk) disable iff (rst) fill_count <= win_len)
    else $error("fill count above window length");

  // The ring position stays inside the window.
  assert property (@(posedge clk) disable iff (rst) CW'(write_slot) < CW'(win_len))
    else $error("write slot outside the window");

  // A delivered result always covers at least one sample.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_held != '0 && out_held <= win_len))
    else $error("result with an impossible sample count");

endmodule

// File: src/moving_average_filter.sv
`timescale 1ns / 1ps
// Moving average of signed 32-bit samples over the last window_len samples.
//
// Input stream s_*: one sample per transfer in s_tdata. Output stream m_*:
// one result per sample, holding the mean (truncated toward zero) and the
// number of samples it covers. Configuration: a write on cfg_we sets the
// window length (0 acts as 1, values above WINDOW_MAX act as WINDOW_MAX)
// and clears the history, fill count and running sum. Write it only while
// no sample is in flight.
//
// Each sample takes a fixed sequence: ring read, subtract of the oldest
// sample, add and ring write, then a bit-serial restoring division with one
// quotient bit per cycle over the running-sum width (38 bits for the
// default WINDOW_MAX). A result enters the output register when the division
// ends and that register is free, and the next sample can be taken in the cycle
// after that, so the block works on one sample at a time.
// The output register lets the next sample start while a result waits;
// a stalled receiver holds the block only once a second result is ready.
// Reset is synchronous: window length 8, empty window, no result pending.

module moving_average_filter #(
  parameter int unsigned WINDOW_MAX = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [6:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] sample
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [31:0] mean, [38:32] held, [39] zero
);
  import maf_pkg::*;

  cmd_t              cmd;
  stat_t             stat;
  logic [DATA_W-1:0] mean;
  logic [LEN_W-1:0]  held;

  maf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  maf_datapath #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .sample    (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_mean  (mean),
    .out_held  (held)
  );

  assign m_tdata = {1'b0, held, mean};

endmodule
